// ===== hw/rtl/pli_pkg.sv =====
// shared types and constants for the piecewise linear interpolation core
// used by pli_muldiv and piecewise_linear_interp_core; no dependencies
package pli_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 256;

  localparam int DATA_W    = 32;  // Q16.16 words
  localparam int CNT_W     = 9;   // point count and search positions
  localparam int IDX_W     = 8;   // table slot of a breakpoint write
  localparam int CFG_IDX_W = 2;
  localparam int MAG_W     = 32;  // magnitude of a 33-bit difference
  localparam int PROD_W    = 2 * MAG_W;
  localparam int QUO_W     = 34;  // enough to hold the quotient limit

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_VALUE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_VALUE = 2'd2;

  // request function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // result region codes
  localparam logic [1:0] REGION_BELOW  = 2'd0;
  localparam logic [1:0] REGION_EXACT  = 2'd1;
  localparam logic [1:0] REGION_INTERP = 2'd2;
  localparam logic [1:0] REGION_ABOVE  = 2'd3;

  // operands for the multiply and divide unit, all magnitudes
  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] mag_a;
    logic [MAG_W-1:0] mag_b;
    logic [MAG_W-1:0] mag_d;
  } md_req_t;

  // clamped quotient, valid while done is high
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } md_res_t;

endpackage

// ===== hw/rtl/piecewise_linear_interp_core.sv =====
// top level of the piecewise linear interpolation core (numpy interp style)
// breakpoint tables in two synchronous memories; depends on pli_pkg, pli_muldiv
//
// A request with func = write stores one breakpoint (x, y) in a table slot and
// produces no result. A query binary-searches the first point_count
// breakpoints (x sorted ascending, Q16.16) for the first x not below the
// query and answers with right_value, the exact y, left_value or a linear
// interpolation. Queries are handled one at a time. Each halving step of the
// search issues a probe read of the x table (S_SRD) and then compares the
// registered probe (S_SCMP); a boundary or exact answer is settled in S_RES or
// S_CHK1, an interpolation goes on through S_CHK0 and S_ARITH, the multiplier
// and the two-bits-per-cycle divider. A finished result waits in the output
// register while the next request is already taken. Table entries have no
// reset value and are read only up to point_count; configuration must be
// written only while the core is idle, which the core itself does not enforce.
module piecewise_linear_interp_core #(
  parameter int TABLE_DEPTH = pli_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [pli_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pli_pkg::DATA_W-1:0]        cfg_wdata,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [pli_pkg::IDX_W-1:0]         in_entry_index,
  input  logic signed [pli_pkg::DATA_W-1:0] in_point_x,
  input  logic signed [pli_pkg::DATA_W-1:0] in_point_y,
  input  logic signed [pli_pkg::DATA_W-1:0] in_query_x,
  input  logic                              in_last_query,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pli_pkg::DATA_W-1:0] out_result_y,
  output logic [1:0]                        out_region,
  output logic                              out_last_result
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int DW  = pli_pkg::DATA_W;
  localparam int CW  = pli_pkg::CNT_W;
  localparam int SW  = DW + 4;  // final sum before saturation

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_SRD   = 8'b00000010,  // issue search probe read
    S_SCMP  = 8'b00000100,  // compare probe, narrow the range
    S_RES   = 8'b00001000,  // classify position, read upper neighbor
    S_CHK1  = 8'b00010000,  // exact match check, read lower neighbor
    S_CHK0  = 8'b00100000,  // differences, start multiply/divide
    S_ARITH = 8'b01000000,  // wait for quotient, add and saturate
    S_FIN   = 8'b10000000   // hand result to the output register
  } state_t;

  // configuration registers
  logic [CW-1:0]        pc_r;
  logic signed [DW-1:0] left_r, right_r;

  // breakpoint tables, no reset
  logic [DW-1:0] mem_x [TABLE_DEPTH];
  logic [DW-1:0] mem_y [TABLE_DEPTH];
  logic signed [DW-1:0] rd_x_r, rd_y_r;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 wr_en;

  state_t               state_r, state_nxt;
  logic signed [DW-1:0] q_r, q_nxt;
  logic                 last_r, last_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic signed [DW-1:0] x1_r, x1_nxt, y1_r, y1_nxt, y0_r, y0_nxt;
  logic                 neg_r, neg_nxt;
  logic signed [DW-1:0] res_y_r, res_y_nxt;
  logic [1:0]           res_region_r, res_region_nxt;

  // output register
  logic                 out_valid_r;
  logic signed [DW-1:0] out_y_r;
  logic [1:0]           out_region_r;
  logic                 out_last_r;

  logic                 in_acc;
  logic [CW-1:0]        cnt_eff;
  logic [CW-1:0]        half, probe, rd_pos;
  logic [AW+CW-1:0]     rd_ext;
  logic [AW+pli_pkg::IDX_W-1:0] wr_ext;

  logic signed [DW:0]   dy, dq, den;
  logic [pli_pkg::MAG_W-1:0] mdy, mdq, mden;
  logic signed [SW-1:0] y0_ext, quo_ext, sum;

  pli_pkg::md_req_t md_req;
  pli_pkg::md_res_t md_res;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // a count beyond the table depth is treated as the depth
  assign cnt_eff = (32'(pc_r) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : pc_r;

  // table write: a slot beyond the depth is dropped
  assign wr_ext  = {{AW{1'b0}}, in_entry_index};
  assign wr_addr = wr_ext[AW-1:0];
  assign wr_en   = in_acc && (in_func == pli_pkg::FUNC_WRITE)
                   && (32'(in_entry_index) < TABLE_DEPTH);

  // search probe
  assign half  = n_r >> 1;
  assign probe = lo_r + half;

  always_comb begin
    case (state_r)
      S_SRD:   rd_pos = probe;
      S_CHK1:  rd_pos = lo_r - 1'b1;
      default: rd_pos = lo_r;
    endcase
  end
  assign rd_ext  = {{AW{1'b0}}, rd_pos};
  assign rd_addr = rd_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= in_point_x;
      mem_y[wr_addr] <= in_point_y;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  // differences against the lower neighbor, which arrives in S_CHK0
  assign dy   = 33'(y1_r) - 33'(rd_y_r);
  assign dq   = 33'(q_r) - 33'(rd_x_r);
  assign den  = 33'(x1_r) - 33'(rd_x_r);
  assign mdy  = dy[DW]  ? 32'(-dy)  : dy[DW-1:0];
  assign mdq  = dq[DW]  ? 32'(-dq)  : dq[DW-1:0];
  assign mden = den[DW] ? 32'(-den) : den[DW-1:0];

  assign md_req.start = (state_r == S_CHK0) && (den != '0);
  assign md_req.mag_a = mdy;
  assign md_req.mag_b = mdq;
  assign md_req.mag_d = mden;

  pli_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .res   (md_res)
  );

  // y0 plus or minus the clamped quotient
  assign y0_ext  = SW'(y0_r);
  assign quo_ext = {{(SW-pli_pkg::QUO_W){1'b0}}, md_res.quo};
  assign sum     = neg_r ? (y0_ext - quo_ext) : (y0_ext + quo_ext);

  always_comb begin
    state_nxt      = state_r;
    q_nxt          = q_r;
    last_nxt       = last_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    n_nxt          = n_r;
    x1_nxt         = x1_r;
    y1_nxt         = y1_r;
    y0_nxt         = y0_r;
    neg_nxt        = neg_r;
    res_y_nxt      = res_y_r;
    res_region_nxt = res_region_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_func == pli_pkg::FUNC_QUERY) begin
          q_nxt     = in_query_x;
          last_nxt  = in_last_query;
          count_nxt = cnt_eff;
          lo_nxt    = '0;
          n_nxt     = cnt_eff;
          state_nxt = (cnt_eff == '0) ? S_RES : S_SRD;
        end
      end
      S_SRD: begin
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (rd_x_r < q_r) begin
          lo_nxt = probe + 1'b1;
          n_nxt  = n_r - half - 1'b1;
        end else begin
          n_nxt  = half;
        end
        state_nxt = (n_nxt == '0) ? S_RES : S_SRD;
      end
      S_RES: begin
        if (lo_r >= count_r) begin
          res_y_nxt      = right_r;
          res_region_nxt = pli_pkg::REGION_ABOVE;
          state_nxt      = S_FIN;
        end else begin
          state_nxt = S_CHK1;
        end
      end
      S_CHK1: begin
        x1_nxt = rd_x_r;
        y1_nxt = rd_y_r;
        if (rd_x_r == q_r) begin
          res_y_nxt      = rd_y_r;
          res_region_nxt = pli_pkg::REGION_EXACT;
          state_nxt      = S_FIN;
        end else if (lo_r == '0) begin
          res_y_nxt      = left_r;
          res_region_nxt = pli_pkg::REGION_BELOW;
          state_nxt      = S_FIN;
        end else begin
          state_nxt = S_CHK0;
        end
      end
      S_CHK0: begin
        y0_nxt         = rd_y_r;
        neg_nxt        = dy[DW] ^ dq[DW] ^ den[DW];
        res_region_nxt = pli_pkg::REGION_INTERP;
        if (den == '0) begin
          // equal neighboring x answers the lower y
          res_y_nxt = rd_y_r;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_ARITH;
        end
      end
      S_ARITH: begin
        if (md_res.done) begin
          if (sum > SW'(32'sh7fff_ffff)) begin
            res_y_nxt = 32'sh7fff_ffff;
          end else if (sum < -SW'(33'sh0_8000_0000)) begin
            res_y_nxt = 32'sh8000_0000;
          end else begin
            res_y_nxt = sum[DW-1:0];
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      left_r      <= '0;
      right_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          pli_pkg::CFG_POINT_COUNT: pc_r    <= cfg_wdata[CW-1:0];
          pli_pkg::CFG_LEFT_VALUE:  left_r  <= cfg_wdata;
          pli_pkg::CFG_RIGHT_VALUE: right_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    q_r          <= q_nxt;
    last_r       <= last_nxt;
    count_r      <= count_nxt;
    lo_r         <= lo_nxt;
    n_r          <= n_nxt;
    x1_r         <= x1_nxt;
    y1_r         <= y1_nxt;
    y0_r         <= y0_nxt;
    neg_r        <= neg_nxt;
    res_y_r      <= res_y_nxt;
    res_region_r <= res_region_nxt;
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_y_r      <= res_y_r;
      out_region_r <= res_region_r;
      out_last_r   <= last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_y    = out_y_r;
  assign out_region      = out_region_r;
  assign out_last_result = out_last_r;

endmodule

// ===== hw/rtl/pli_muldiv.sv =====
// sequential multiply then divide: (a * b) / d on unsigned magnitudes
// quotient limited to 2^33; depends on pli_pkg
module pli_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  pli_pkg::md_req_t req,
  output pli_pkg::md_res_t res
);

  localparam int STEPS = pli_pkg::QUO_W / 2;
  localparam int CW    = $clog2(STEPS + 1);
  localparam int HI_W  = pli_pkg::PROD_W - pli_pkg::QUO_W;
  localparam logic [pli_pkg::QUO_W-1:0] QUO_LIM = {1'b1, {(pli_pkg::QUO_W-1){1'b0}}};

  typedef enum logic [4:0] {
    MD_IDLE = 5'b00001,
    MD_MUL  = 5'b00010,
    MD_INIT = 5'b00100,
    MD_RUN  = 5'b01000,
    MD_DONE = 5'b10000
  } md_state_t;

  md_state_t                   st_r, st_nxt;
  logic [pli_pkg::MAG_W-1:0]   a_r, b_r, d_r;
  logic [pli_pkg::PROD_W-1:0]  prod_r;
  logic [pli_pkg::MAG_W-1:0]   rem_r, rem_nxt;
  logic [pli_pkg::QUO_W-1:0]   dvd_r, dvd_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        over_r, over_nxt;
  logic                        done_r;
  logic [pli_pkg::QUO_W-1:0]   quo_r;

  logic [pli_pkg::MAG_W-1:0]   prod_hi;
  logic [pli_pkg::MAG_W:0]     dv_ext, t1, t2, r1, r2;
  logic                        ge1, ge2;

  assign prod_hi = {{(pli_pkg::MAG_W-HI_W){1'b0}}, prod_r[pli_pkg::PROD_W-1:pli_pkg::QUO_W]};
  assign dv_ext  = {1'b0, d_r};

  // two restoring steps per cycle
  always_comb begin
    t1  = {rem_r, dvd_r[pli_pkg::QUO_W-1]};
    ge1 = (t1 >= dv_ext);
    r1  = ge1 ? (t1 - dv_ext) : t1;
    t2  = {r1[pli_pkg::MAG_W-1:0], dvd_r[pli_pkg::QUO_W-2]};
    ge2 = (t2 >= dv_ext);
    r2  = ge2 ? (t2 - dv_ext) : t2;
  end

  always_comb begin
    st_nxt   = st_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;
    over_nxt = over_r;
    case (st_r)
      MD_IDLE: begin
        if (req.start) begin
          st_nxt = MD_MUL;
        end
      end
      MD_MUL: begin
        st_nxt = MD_INIT;
      end
      MD_INIT: begin
        // a quotient of 2^34 or more is clamped anyway
        over_nxt = (prod_hi >= d_r);
        rem_nxt  = prod_hi;
        dvd_nxt  = prod_r[pli_pkg::QUO_W-1:0];
        cnt_nxt  = CW'(STEPS);
        st_nxt   = over_nxt ? MD_DONE : MD_RUN;
      end
      MD_RUN: begin
        rem_nxt = r2[pli_pkg::MAG_W-1:0];
        dvd_nxt = {dvd_r[pli_pkg::QUO_W-3:0], ge1, ge2};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          st_nxt = MD_DONE;
        end
      end
      MD_DONE: begin
        st_nxt = MD_IDLE;
      end
      default: begin
        st_nxt = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MD_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == MD_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == MD_IDLE && req.start) begin
      a_r <= req.mag_a;
      b_r <= req.mag_b;
      d_r <= req.mag_d;
    end
    prod_r <= a_r * b_r;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    cnt_r  <= cnt_nxt;
    over_r <= over_nxt;
    if (st_r == MD_DONE) begin
      quo_r <= (over_r || dvd_r > QUO_LIM) ? QUO_LIM : dvd_r;
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for piecewise_linear_interp_core: breakpoint writes and queries
// through a bursty request driver, checked against an in-bench interpolation predictor
// depends on pli_pkg and the core rtl only
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pli_pkg::*;

  localparam int DEPTH          = DEFAULT_TABLE_DEPTH;
  localparam int TARGET_ITEMS   = 1150;  // stop generating once this many requests are queued
  localparam int SETTLE_CYCLES  = 64;    // longer than the slowest query at full count
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake and no configuration write

  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;

  // one request as it goes onto the input channel
  typedef struct packed {
    logic                     func;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] query_x;
    logic                     last_query;
  } interp_req_t;

  // one answer as it should leave the result channel
  typedef struct packed {
    logic signed [DATA_W-1:0] result_y;
    logic [1:0]               region;
    logic                     last_result;
  } interp_ans_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_func = FUNC_WRITE;
  logic [IDX_W-1:0]         in_entry_index = '0;
  logic signed [DATA_W-1:0] in_point_x = '0;
  logic signed [DATA_W-1:0] in_point_y = '0;
  logic signed [DATA_W-1:0] in_query_x = '0;
  logic                     in_last_query = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_result_y;
  logic [1:0]               out_region;
  logic                     out_last_result;

  piecewise_linear_interp_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_entry_index  (in_entry_index),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_query_x      (in_query_x),
    .in_last_query   (in_last_query),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_y    (out_result_y),
    .out_region      (out_region),
    .out_last_result (out_last_result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state: shadow registers and the breakpoint tables as the core holds them
  logic [CNT_W-1:0]         shadow_count = '0;
  logic signed [DATA_W-1:0] shadow_left = '0;
  logic signed [DATA_W-1:0] shadow_right = '0;
  logic signed [DATA_W-1:0] bp_x [DEPTH];
  logic signed [DATA_W-1:0] bp_y [DEPTH];

  // generator-side copy of the x table, so queries can aim at breakpoints and gaps
  int gen_x [DEPTH];

  interp_req_t req_q[$];     // requests not yet put on the channel
  interp_ans_t answer_q[$];  // predicted answers, oldest first
  int reqs_queued = 0;       // written by the stimulus only
  int reqs_taken  = 0;       // written by the driver only
  int fail_count  = 0;
  int quiet_cycles = 0;

  // numpy-interp style answer for one query against the current shadow state
  function automatic interp_ans_t interp_answer(input logic signed [DATA_W-1:0] qx,
                                                input logic lq);
    int unsigned cnt, lo, n, half;
    longint x0, x1, y0, y1, dy, dq, den, r, qs;
    longint unsigned mag_dy, mag_dq, mag_den, quo;
    bit neg;
    interp_ans_t ans;
    cnt = (shadow_count > DEPTH) ? DEPTH : shadow_count;
    lo  = 0;
    n   = cnt;
    // lower-bound search: first x not below the query
    while (n > 0) begin
      half = n / 2;
      if (bp_x[lo + half] < qx) begin
        lo += half + 1;
        n  -= half + 1;
      end else begin
        n = half;
      end
    end
    ans.last_result = lq;
    if (lo >= cnt) begin
      ans.result_y = shadow_right;
      ans.region   = REGION_ABOVE;
    end else if (bp_x[lo] == qx) begin
      ans.result_y = bp_y[lo];
      ans.region   = REGION_EXACT;
    end else if (lo == 0) begin
      ans.result_y = shadow_left;
      ans.region   = REGION_BELOW;
    end else begin
      x0  = bp_x[lo - 1];
      x1  = bp_x[lo];
      y0  = bp_y[lo - 1];
      y1  = bp_y[lo];
      dy  = y1 - y0;
      dq  = qx - x0;
      den = x1 - x0;
      if (den == 0) begin
        r = y0;
      end else begin
        // magnitudes first, so the 64-bit product never overflows
        mag_dy  = (dy < 0) ? -dy : dy;
        mag_dq  = (dq < 0) ? -dq : dq;
        mag_den = (den < 0) ? -den : den;
        quo = (mag_dy * mag_dq) / mag_den;
        neg = (dy < 0) != (dq < 0);
        if (den < 0) neg = !neg;
        if (quo > (64'd1 << 33)) quo = 64'd1 << 33;
        qs = longint'(quo);
        r  = neg ? y0 - qs : y0 + qs;
        if (r > longint'(Q_MAX)) r = Q_MAX;
        if (r < longint'(Q_MIN)) r = Q_MIN;
      end
      ans.result_y = r[DATA_W-1:0];
      ans.region   = REGION_INTERP;
    end
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  interp_req_t cur_req;
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : driver
    bit show;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // the request on the wire was taken at this edge: update the predictor
      if (in_valid && in_ready) begin
        reqs_taken++;
        if (cur_req.func == FUNC_WRITE) begin
          bp_x[cur_req.entry_index] = cur_req.point_x;
          bp_y[cur_req.entry_index] = cur_req.point_y;
        end else begin
          answer_q.push_back(interp_answer(cur_req.query_x, cur_req.last_query));
        end
      end
      // channel free: either idle through the gap or present the next request
      if (!in_valid || in_ready) begin
        show = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          show    = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            // about a quarter of bursts run straight into the next one
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        in_valid <= show;
        if (show) begin
          in_func        <= cur_req.func;
          in_entry_index <= cur_req.entry_index;
          in_point_x     <= cur_req.point_x;
          in_point_y     <= cur_req.point_y;
          in_query_x     <= cur_req.query_x;
          in_last_query  <= cur_req.last_query;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and receiver back-pressure
  // ---------------------------------------------------------------------------
  int          ready_mode = 0;
  int          mode_left  = 0;
  logic [31:0] ready_pat  = 32'h1;

  always @(posedge clk) begin : monitor
    interp_ans_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          $error("result with no query waiting: result_y %0d region %0d last_result %0d",
                 out_result_y, out_region, out_last_result);
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          if (out_result_y !== want.result_y) begin
            $error("result_y mismatch: expected %0d, actual %0d", want.result_y, out_result_y);
            fail_count++;
          end
          if (out_region !== want.region) begin
            $error("region mismatch: expected %0d, actual %0d", want.region, out_region);
            fail_count++;
          end
          if (out_last_result !== want.last_result) begin
            $error("last_result mismatch: expected %0d, actual %0d",
                   want.last_result, out_last_result);
            fail_count++;
          end
        end
      end
      // stretches of always-ready, a rotating stall pattern, or coin flips
      if (mode_left == 0) begin
        mode_left  = $urandom_range(20, 200);
        ready_mode = $urandom_range(0, 2);
        ready_pat  = $urandom | 32'h1;
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= ready_pat[0];
          ready_pat = {ready_pat[0], ready_pat[31:1]};
        end
        default: begin
          out_ready <= $urandom_range(0, 1);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: no handshake or configuration write for too long means the core hung
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // all three registers back to back; only called while the core is idle
  task automatic program_regs(input int unsigned cnt, input logic signed [DATA_W-1:0] lv,
                              input logic signed [DATA_W-1:0] rv);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_POINT_COUNT;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_index <= CFG_LEFT_VALUE;
    cfg_wdata <= lv;
    @(posedge clk);
    cfg_index <= CFG_RIGHT_VALUE;
    cfg_wdata <= rv;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_count = cnt[CNT_W-1:0];
    shadow_left  = lv;
    shadow_right = rv;
  endtask

  // breakpoint write; the unused query fields carry noise
  task automatic push_write(input logic [IDX_W-1:0] idx, input logic signed [DATA_W-1:0] x,
                            input logic signed [DATA_W-1:0] y);
    interp_req_t r;
    r.func        = FUNC_WRITE;
    r.entry_index = idx;
    r.point_x     = x;
    r.point_y     = y;
    r.query_x     = $urandom;
    r.last_query  = $urandom_range(0, 1);
    req_q.push_back(r);
    reqs_queued++;
    gen_x[idx] = x;
  endtask

  // query; the unused write fields carry noise
  task automatic push_query(input logic signed [DATA_W-1:0] q, input logic lq);
    interp_req_t r;
    r.func        = FUNC_QUERY;
    r.entry_index = $urandom;
    r.point_x     = $urandom;
    r.point_y     = $urandom;
    r.query_x     = q;
    r.last_query  = lq;
    req_q.push_back(r);
    reqs_queued++;
  endtask

  // everything taken, every answer back, then time for a trailing write to land
  task automatic wait_drained;
    while (reqs_taken != reqs_queued || answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus: directed corners first, then random phases
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase, cnt, eff, nq, k, i, j, m, tmp, base;
    int xs [DEPTH];
    longint span, val;
    logic signed [DATA_W-1:0] lv, rv, q, y;
    logic lq;

    for (i = 0; i < DEPTH; i++) begin
      bp_x[i]  = '0;
      bp_y[i]  = '0;
      gen_x[i] = 0;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: every query lands above, whatever its value
    program_regs(0, Q_MIN, Q_MAX);
    push_query(Q_MIN, 1'b0);
    push_query(0, 1'b0);
    push_query(Q_MAX, 1'b1);
    wait_drained();

    // breakpoints at the x extremes with extreme y swings
    program_regs(4, -1, 1);
    push_write(8'd0, Q_MIN, Q_MAX);
    push_write(8'd1, -5, Q_MIN);
    push_write(8'd2, 7, 0);
    push_write(8'd3, Q_MAX, Q_MIN);
    push_write(8'd255, Q_MAX, Q_MAX);
    push_query(Q_MIN, 1'b0);   // exact at the first point
    push_query(-1000, 1'b0);   // widest y span, negative slope
    push_query(0, 1'b0);
    push_query(7, 1'b0);
    push_query(Q_MAX, 1'b1);   // exact at the last point
    wait_drained();

    // small table with room on both sides
    program_regs(3, 32'sh0001_0000, -32'sh0001_0000);
    push_write(8'd0, -100, 1000);
    push_write(8'd1, 0, -1000);
    push_write(8'd2, 100, 32'sh0010_0000);
    push_query(Q_MIN, 1'b0);
    push_query(-101, 1'b0);
    push_query(-100, 1'b0);
    push_query(-37, 1'b0);
    push_query(50, 1'b0);
    push_query(101, 1'b0);
    push_query(Q_MAX, 1'b1);
    wait_drained();

    // random phases: a sorted table, then a batch of aimed queries with a little noise
    phase = 0;
    while (reqs_queued < TARGET_ITEMS) begin
      if (phase == 4) begin
        cnt = DEPTH;                                    // full table once
      end else if (phase == 5) begin
        cnt = 511;                                      // count past depth, full table reused
      end else if (phase > 5 && $urandom_range(0, 9) == 0) begin
        cnt = $urandom_range(DEPTH + 1, 511);
      end else begin
        k = $urandom_range(0, 19);
        cnt = (k == 0) ? 0 : (k == 1) ? 1 : $urandom_range(2, 16);
      end
      eff = (cnt > DEPTH) ? DEPTH : cnt;

      lv = ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) == 0) ? Q_MIN : Q_MAX)
                                       : $urandom;
      rv = ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) == 0) ? Q_MIN : Q_MAX)
                                       : $urandom;
      program_regs(cnt, lv, rv);

      // counts past depth keep whatever the full table left behind
      if (cnt <= DEPTH) begin
        k = $urandom_range(0, 2);
        if (k == 0) begin
          // spread over the whole range, sorted in place
          for (i = 0; i < eff; i++) xs[i] = $urandom;
          for (i = 1; i < eff; i++) begin
            tmp = xs[i];
            m   = i - 1;
            while (m >= 0 && xs[m] > tmp) begin
              xs[m + 1] = xs[m];
              m--;
            end
            xs[m + 1] = tmp;
          end
        end else begin
          // dense run of breakpoints; optionally pinned to one end of the range
          base = -int'($urandom_range(0, 32'h4000_0000));
          for (i = 0; i < eff; i++) begin
            base += $urandom_range(1, 32'h30000);
            xs[i] = base;
          end
          if (k == 2 && eff > 0) begin
            if ($urandom_range(0, 1) == 0) xs[0] = Q_MIN;
            else xs[eff - 1] = Q_MAX;
          end
        end
        for (i = 0; i < eff; i++) begin
          y = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 0) ? Q_MIN : Q_MAX)
                                          : $urandom;
          push_write(i[IDX_W-1:0], xs[i], y);
        end
      end

      nq = (eff == DEPTH) ? 40 : $urandom_range(4, 24);
      for (j = 0; j < nq; j++) begin
        // occasional stray write, which may leave the table unsorted
        if ($urandom_range(0, 99) < 6) push_write($urandom, $urandom, $urandom);
        k = $urandom_range(0, 99);
        if (eff == 0 || k < 8) begin
          q = (k % 3 == 0) ? Q_MIN : (k % 3 == 1) ? Q_MAX : $urandom;
        end else if (k < 35) begin
          q = gen_x[$urandom_range(0, eff - 1)];
        end else if (k < 80 && eff >= 2) begin
          // strictly between two neighboring breakpoints when there is room
          i    = $urandom_range(1, eff - 1);
          span = longint'(gen_x[i]) - longint'(gen_x[i - 1]);
          if (span > 1) val = longint'(gen_x[i - 1]) + 1 + longint'($urandom % (span - 1));
          else val = gen_x[i];
          q = val[DATA_W-1:0];
        end else if (k < 90) begin
          span = longint'(gen_x[0]) - longint'(Q_MIN);
          if (span > 0) val = longint'(gen_x[0]) - 1 - longint'($urandom % span);
          else val = Q_MIN;
          q = val[DATA_W-1:0];
        end else begin
          span = longint'(Q_MAX) - longint'(gen_x[eff - 1]);
          if (span > 0) val = longint'(gen_x[eff - 1]) + 1 + longint'($urandom % span);
          else val = Q_MAX;
          q = val[DATA_W-1:0];
        end
        lq = (j == nq - 1) || ($urandom_range(0, 9) == 0);
        push_query(q, lq);
      end

      wait_drained();
      phase++;
    end

    if (fail_count == 0 && answer_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
